>>> design/lzwc9_pkg.sv
// Package: shared types and constants for the fixed-width LZW compressor.
package lzwc9_pkg;

	// Stream header bytes
	localparam logic [7:0] HDR_MAGIC0 = 8'h1f;
	localparam logic [7:0] HDR_MAGIC1 = 8'h9d;
	localparam logic [7:0] HDR_FLAGS  = 8'h80;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDR,
		ST_START,
		ST_SEARCH,
		ST_ENCODE,
		ST_DRAIN,
		ST_TAIL
	} lzwc9_state_t;

	// What the drain loop returns to once fewer than eight bits remain
	typedef enum logic [1:0] {
		PH_DATA,
		PH_FINAL,
		PH_PAD
	} lzwc9_phase_t;

endpackage

>>> design/lzwc9_in_if.sv
// Interface: input byte channel (valid/ready with data and last).
interface lzwc9_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;
	logic       last;

	modport source (output valid, output data, output last, input ready);
	modport sink (input valid, input data, input last, output ready);
endinterface

>>> design/lzwc9_out_if.sv
// Interface: output byte channel (valid/ready with out_byte and last_out).
interface lzwc9_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_out;

	modport source (output valid, output out_byte, output last_out, input ready);
	modport sink (input valid, input out_byte, input last_out, output ready);
endinterface

>>> design/lzwc9_cell.sv
// Dictionary cell: holds one (prefix, byte) entry and flags an exact match.
module lzwc9_cell #(
	parameter int CW   = 9,
	parameter int CODE = 257
) (
	input  logic           clk,
	input  logic           wr_en,
	input  logic [CW:0]    next_code,
	input  logic [CW+7:0]  key,
	output logic           hit
);

	logic [CW+7:0] entry_q;
	logic          hit_q;

	// Entry write when this cell's code is the next one to be assigned
	always_ff @(posedge clk) begin
		if (wr_en && next_code == (CW+1)'(CODE)) begin
			entry_q <= key;
		end
	end

	// Only assigned codes take part in the match
	always_ff @(posedge clk) begin
		hit_q <= ((CW+1)'(CODE) < next_code) && (entry_q == key);
	end

	assign hit = hit_q;

endmodule

>>> design/lzw_compressor_9bit_core.sv
// LZW compressor with fixed-width codes, 3-byte header and MSB-first bit packing.
// Each input byte is a transfer on din; compressed bytes leave on dout, the
// final one with last_out set, after which the block starts a fresh stream.
// The dictionary is a row of 2^CODE_WIDTH-257 cells that all compare the
// current (prefix, byte) key at once; the match is registered in the cells
// and encoded in the next cycle. A matched byte passes IDLE, START, SEARCH,
// ENCODE and TAIL; the first byte of a stream, which only opens the prefix,
// passes IDLE, START and TAIL. A miss adds DRAIN, which sends each packed
// byte; the first byte of a stream also sends the header in HDR; the last
// byte drains final and padding codes. A busy dout stretches the byte phases.
module lzw_compressor_9bit_core
	import lzwc9_pkg::*;
#(
	parameter int CODE_WIDTH = 9
) (
	input  logic       clk,
	input  logic       arst_n,
	lzwc9_in_if.sink   din,
	lzwc9_out_if.source dout
);

	localparam int CW     = CODE_WIDTH;
	localparam int NCELL  = (1 << CW) - 257;
	localparam int BW     = CW + 7;
	localparam int CNTW   = $clog2(CW + 8);
	localparam logic [CW:0]     FIRST_CODE = (CW+1)'(257);
	localparam logic [CW:0]     CODE_STEP  = (CW+1)'(1);
	localparam logic [CW-1:0]   PAD_CODE   = CW'(256);
	localparam logic [CNTW-1:0] BYTE_BITS  = CNTW'(8);
	localparam logic [CNTW-1:0] CODE_BITS  = CNTW'(CW);

	lzwc9_state_t  st_q, st_d;
	lzwc9_phase_t  ph_q, ph_d;
	logic [1:0]    hdr_cnt_q, hdr_cnt_d;
	logic [7:0]    data_q, data_d;
	logic          fin_q, fin_d;
	logic [CW-1:0] prefix_q, prefix_d;
	logic          have_q, have_d;
	logic          hdr_done_q, hdr_done_d;
	logic [BW-1:0] buf_q, buf_d;
	logic [CNTW-1:0] cnt_q, cnt_d;
	logic [CW:0]   next_code_q, next_code_d;
	logic          ov_q, ov_d;
	logic [7:0]    ob_q, ob_d;
	logic          ol_q, ol_d;

	logic [NCELL-1:0] hits;
	logic [CW-1:0]    hit_code;
	logic             any_hit;
	logic             wr_en;
	logic             emit_ok;
	logic [CW+7:0]    key;
	logic [CNTW-1:0]  cnt_new;
	logic [BW-1:0]    shifted;

	assign key = {prefix_q, data_q};

	// Row of dictionary cells
	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		lzwc9_cell #(.CW(CW), .CODE(g + 257)) u_cell (
			.clk       (clk),
			.wr_en     (wr_en),
			.next_code (next_code_q),
			.key       (key),
			.hit       (hits[g])
		);
	end

	// Encode the (at most one) matching cell into its code
	always_comb begin
		hit_code = '0;
		for (int i = 0; i < NCELL; i++) begin
			if (hits[i]) hit_code = hit_code | CW'(i + 257);
		end
	end
	assign any_hit = |hits;

	assign emit_ok = !ov_q || dout.ready;
	assign cnt_new = cnt_q - BYTE_BITS;
	assign shifted = buf_q >> (cnt_q - BYTE_BITS);

	// Sequencer: next state and datapath updates
	always_comb begin
		st_d        = st_q;
		ph_d        = ph_q;
		hdr_cnt_d   = hdr_cnt_q;
		data_d      = data_q;
		fin_d       = fin_q;
		prefix_d    = prefix_q;
		have_d      = have_q;
		hdr_done_d  = hdr_done_q;
		buf_d       = buf_q;
		cnt_d       = cnt_q;
		next_code_d = next_code_q;
		ov_d        = ov_q && !dout.ready;
		ob_d        = ob_q;
		ol_d        = ol_q;
		wr_en       = 1'b0;
		din.ready   = 1'b0;

		case (st_q)
			ST_IDLE: begin
				din.ready = 1'b1;
				if (din.valid) begin
					data_d = din.data;
					fin_d  = din.last;
					st_d   = hdr_done_q ? ST_START : ST_HDR;
				end
			end
			ST_HDR: begin
				if (emit_ok) begin
					ov_d = 1'b1;
					ol_d = 1'b0;
					case (hdr_cnt_q)
						2'd0:    ob_d = HDR_MAGIC0;
						2'd1:    ob_d = HDR_MAGIC1;
						default: ob_d = HDR_FLAGS | 8'(CW);
					endcase
					if (hdr_cnt_q == 2'd2) begin
						hdr_cnt_d  = 2'd0;
						hdr_done_d = 1'b1;
						st_d       = ST_START;
					end else begin
						hdr_cnt_d = hdr_cnt_q + 2'd1;
					end
				end
			end
			ST_START: begin
				if (!have_q) begin
					prefix_d = CW'(data_q);
					have_d   = 1'b1;
					st_d     = ST_TAIL;
				end else begin
					st_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				st_d = ST_ENCODE;
			end
			ST_ENCODE: begin
				if (any_hit) begin
					prefix_d = hit_code;
					st_d     = ST_TAIL;
				end else begin
					buf_d = (buf_q << CW) | BW'(prefix_q);
					cnt_d = cnt_q + CODE_BITS;
					if (!next_code_q[CW]) begin
						wr_en       = 1'b1;
						next_code_d = next_code_q + CODE_STEP;
					end
					prefix_d = CW'(data_q);
					ph_d     = PH_DATA;
					st_d     = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (cnt_q >= BYTE_BITS) begin
					if (emit_ok) begin
						ov_d  = 1'b1;
						ob_d  = shifted[7:0];
						ol_d  = (ph_q != PH_DATA) && (cnt_new == '0);
						cnt_d = cnt_new;
						for (int i = 0; i < BW; i++) begin
							buf_d[i] = buf_q[i] && (CNTW'(i) < cnt_new);
						end
					end
				end else if (ph_q == PH_DATA) begin
					st_d = ST_TAIL;
				end else if (cnt_q != '0) begin
					buf_d = (buf_q << CW) | BW'(PAD_CODE);
					cnt_d = cnt_q + CODE_BITS;
					ph_d  = PH_PAD;
				end else begin
					// Stream complete: back to a fresh stream
					have_d      = 1'b0;
					hdr_done_d  = 1'b0;
					prefix_d    = '0;
					buf_d       = '0;
					next_code_d = FIRST_CODE;
					st_d        = ST_IDLE;
				end
			end
			ST_TAIL: begin
				if (fin_q) begin
					buf_d = (buf_q << CW) | BW'(prefix_q);
					cnt_d = cnt_q + CODE_BITS;
					ph_d  = PH_FINAL;
					st_d  = ST_DRAIN;
				end else begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			ph_q        <= PH_DATA;
			hdr_cnt_q   <= 2'd0;
			prefix_q    <= '0;
			have_q      <= 1'b0;
			hdr_done_q  <= 1'b0;
			buf_q       <= '0;
			cnt_q       <= '0;
			next_code_q <= FIRST_CODE;
			ov_q        <= 1'b0;
		end else begin
			st_q        <= st_d;
			ph_q        <= ph_d;
			hdr_cnt_q   <= hdr_cnt_d;
			prefix_q    <= prefix_d;
			have_q      <= have_d;
			hdr_done_q  <= hdr_done_d;
			buf_q       <= buf_d;
			cnt_q       <= cnt_d;
			next_code_q <= next_code_d;
			ov_q        <= ov_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		data_q <= data_d;
		fin_q  <= fin_d;
		ob_q   <= ob_d;
		ol_q   <= ol_d;
	end

	assign dout.valid    = ov_q;
	assign dout.out_byte = ob_q;
	assign dout.last_out = ol_q;

endmodule
